// ===== rtl/trap_pkg.sv =====
package trap_pkg;

  // default widths of the speed registers and of the move distance
  localparam int SPEED_BITS_DEF    = 16;
  localparam int DISTANCE_BITS_DEF = 32;

  // width of the signed step count returned per word
  localparam int RATE_BITS = 32;

  // configuration register map
  localparam int REG_IDX_BITS = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_ACCEL       = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_SPEED_LIMIT = 1'b1;

  // profile phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_UP,
    PH_CRUISE,
    PH_DOWN
  } phase_t;

  // planning sequencer
  typedef enum logic [3:0] {
    PL_IDLE,
    PL_HI,
    PL_Q,
    PL_SQ_MUL,
    PL_SQ_CHK,
    PL_MIN,
    PL_V,
    PL_REM,
    PL_CRUISE,
    PL_OFFS
  } plan_state_t;

  // planner status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } plan_stat_t;

endpackage

// ===== rtl/trap_ifs.sv =====
interface trap_in_if #(
  parameter int DISTANCE_BITS = trap_pkg::DISTANCE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [DISTANCE_BITS-1:0] distance;

  modport source (output valid, output func, output distance, input ready);
  modport sink (input valid, input func, input distance, output ready);
endinterface

interface trap_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [trap_pkg::RATE_BITS-1:0] step_rate;
  logic                                  start_refused;
  logic                                  moving;

  modport source (output valid, output step_rate, output start_refused, output moving,
                  input ready);
  modport sink (input valid, input step_rate, input start_refused, input moving,
                output ready);
endinterface

// ===== rtl/trapezoid_step_rate_profile_top.sv =====
// every word gets its result in the cycle after acceptance, held in an output register
// a tick, a refused start or a zero-distance start: one word per cycle while results drain
// a start with a distance holds the input off while the planner works out the move,
// with its divisions done one after another on the shared serial divider
// rst (synchronous, active high) clears the phase, the output valid flag and the config
// registers (acceleration 1, speed limit 0)
module trapezoid_step_rate_profile_top #(
  parameter int SPEED_BITS    = trap_pkg::SPEED_BITS_DEF,
  parameter int DISTANCE_BITS = trap_pkg::DISTANCE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [trap_pkg::REG_IDX_BITS-1:0] wr_index,
  input  logic [SPEED_BITS-1:0]             wr_data,
  trap_in_if.sink                           req,
  trap_out_if.source                        rsp
);

  localparam int DW = (SPEED_BITS > DISTANCE_BITS) ? SPEED_BITS : DISTANCE_BITS;
  localparam int KW = DISTANCE_BITS / 2;
  localparam int RB = trap_pkg::RATE_BITS;

  // config registers
  logic [SPEED_BITS-1:0] accel_per_tick;
  logic [SPEED_BITS-1:0] speed_limit;
  logic [SPEED_BITS-1:0] accel_eff;

  // profile state
  trap_pkg::phase_t phase, phase_next;
  logic          direction_forward;
  logic [DW-1:0] tick_index, tick_next, tick_inc;
  logic [DW-1:0] cur_speed, spd;
  logic [DW-1:0] step_mag;

  // plan from the planner
  trap_pkg::plan_stat_t  pstat;
  logic [KW-1:0]         ramp_ticks;
  logic [DW-1:0]         cruise_ticks;
  logic [DW-1:0]         peak_speed;
  logic [DW-1:0]         ramp_top;
  logic [DW-1:0]         ramp_inc;
  logic [SPEED_BITS-1:0] ramp_offset;
  logic [KW-1:0]         extra_dec;

  // input side
  logic                     accept;
  logic                     neg;
  logic [DISTANCE_BITS-1:0] dist_u;
  logic [DISTANCE_BITS-1:0] mag_u;
  logic [DW-1:0]            mag;
  logic                     plan_start;

  // output register
  logic          rsp_valid;
  logic [RB-1:0] rsp_rate;
  logic          rsp_refused;
  logic          rsp_moving;
  logic [RB-1:0] mag_out;
  logic [RB-1:0] rate;

  // zero acceleration behaves as one
  assign accel_eff = (accel_per_tick == '0) ? SPEED_BITS'(1) : accel_per_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_per_tick <= SPEED_BITS'(1);
      speed_limit    <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        trap_pkg::REG_ACCEL:       accel_per_tick <= wr_data;
        trap_pkg::REG_SPEED_LIMIT: speed_limit    <= wr_data;
        default: ;
      endcase
    end
  end

  // magnitude of the signed distance; the most negative value maps to 2^(n-1)
  assign dist_u = req.distance;
  assign neg    = dist_u[DISTANCE_BITS-1];
  assign mag_u  = neg ? (~dist_u + DISTANCE_BITS'(1)) : dist_u;
  assign mag    = DW'(mag_u);

  // take a word only when the planner is free and the output register can take a result
  assign req.ready = ~pstat.busy & (~rsp_valid | rsp.ready);
  assign accept    = req.valid & req.ready;
  assign plan_start = accept & req.func & (phase == trap_pkg::PH_IDLE) & (mag != '0);

  trap_plan #(
    .SPEED_BITS    (SPEED_BITS),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_plan (
    .clk          (clk),
    .rst          (rst),
    .start        (plan_start),
    .mag          (mag),
    .accel        (accel_eff),
    .speed_limit  (speed_limit),
    .stat         (pstat),
    .ramp_ticks   (ramp_ticks),
    .cruise_ticks (cruise_ticks),
    .peak_speed   (peak_speed),
    .ramp_top     (ramp_top),
    .ramp_inc     (ramp_inc),
    .ramp_offset  (ramp_offset),
    .extra_dec    (extra_dec)
  );

  // one tick of the profile: a single add or subtract on the running speed
  always_comb begin
    phase_next = phase;
    tick_next  = tick_index;
    tick_inc   = tick_index + DW'(1);
    spd        = cur_speed;
    step_mag   = '0;
    unique case (phase)
      trap_pkg::PH_UP: begin
        // first ramp tick starts lowered by the common offset
        spd       = (tick_index == '0) ? (ramp_inc - DW'(ramp_offset))
                                       : (cur_speed + ramp_inc);
        // the first few ramp ticks give one step less
        step_mag  = spd - DW'(tick_index < DW'(extra_dec));
        tick_next = tick_inc;
        if (tick_inc == DW'(ramp_ticks)) begin
          phase_next = (cruise_ticks == '0) ? trap_pkg::PH_DOWN : trap_pkg::PH_CRUISE;
          tick_next  = '0;
        end
      end
      trap_pkg::PH_CRUISE: begin
        step_mag  = peak_speed;
        tick_next = tick_inc;
        if (tick_inc == cruise_ticks) begin
          phase_next = trap_pkg::PH_DOWN;
          tick_next  = '0;
        end
      end
      trap_pkg::PH_DOWN: begin
        spd       = (tick_index == '0) ? ramp_top : (cur_speed - ramp_inc);
        step_mag  = spd;
        tick_next = tick_inc;
        if (tick_inc == DW'(ramp_ticks)) begin
          phase_next = trap_pkg::PH_IDLE;
          tick_next  = '0;
        end
      end
      default: ;
    endcase
  end

  // apply direction at the full output width
  assign mag_out = RB'(step_mag);
  assign rate    = direction_forward ? mag_out : (RB'(0) - mag_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= trap_pkg::PH_IDLE;
      direction_forward <= 1'b0;
      tick_index        <= '0;
      cur_speed         <= '0;
    end else if (pstat.done) begin
      // plan ready: begin the ramp up
      phase      <= trap_pkg::PH_UP;
      tick_index <= '0;
      cur_speed  <= '0;
    end else if (accept) begin
      if (req.func) begin
        if (plan_start) begin
          direction_forward <= ~neg;
        end
      end else begin
        phase      <= phase_next;
        tick_index <= tick_next;
        cur_speed  <= spd;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.func) begin
        rsp_rate    <= '0;
        rsp_refused <= (phase != trap_pkg::PH_IDLE);
        // a refused start leaves the running move in place
        rsp_moving  <= (phase != trap_pkg::PH_IDLE) | (mag != '0);
      end else begin
        rsp_rate    <= rate;
        rsp_refused <= 1'b0;
        rsp_moving  <= (phase_next != trap_pkg::PH_IDLE);
      end
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.step_rate     = $signed(rsp_rate);
  assign rsp.start_refused = rsp_refused;
  assign rsp.moving        = rsp_moving;

endmodule

// ===== rtl/trap_div.sv =====
module trap_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem, quot[W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[W-2:0], ge};
      rem  <= ge ? diff[W-1:0] : shifted[W-1:0];
    end
  end

endmodule

// ===== rtl/trap_plan.sv =====
module trap_plan #(
  parameter int SPEED_BITS    = trap_pkg::SPEED_BITS_DEF,
  parameter int DISTANCE_BITS = trap_pkg::DISTANCE_BITS_DEF,
  localparam int DW = (SPEED_BITS > DISTANCE_BITS) ? SPEED_BITS : DISTANCE_BITS,
  localparam int KW = DISTANCE_BITS / 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        mag,
  input  logic [SPEED_BITS-1:0] accel,
  input  logic [SPEED_BITS-1:0] speed_limit,
  output trap_pkg::plan_stat_t stat,
  output logic [KW-1:0]        ramp_ticks,
  output logic [DW-1:0]        cruise_ticks,
  output logic [DW-1:0]        peak_speed,
  output logic [DW-1:0]        ramp_top,
  output logic [DW-1:0]        ramp_inc,
  output logic [SPEED_BITS-1:0] ramp_offset,
  output logic [KW-1:0]        extra_dec
);

  localparam int BW = $clog2(KW);
  localparam int PW = DW + KW + 1;

  trap_pkg::plan_state_t state, state_next;

  logic [DW-1:0] mag_r;
  logic [DW-1:0] hi;
  logic [DW-1:0] q;
  logic [KW-1:0] k;
  logic [BW-1:0] bitn;
  logic [KW-1:0] cand;
  logic [KW-1:0] n1;
  logic [DW:0]   mag_sum;
  logic [DW-1:0] half;

  logic [DW-1:0] mul_a;
  logic [KW:0]   mul_b;
  logic [PW-1:0] prod;

  logic          div_start;
  logic [DW-1:0] div_a;
  logic [DW-1:0] div_b;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [DW-1:0] div_r;

  trap_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign cand    = k | (KW'(1) << bitn);
  assign n1      = (hi < DW'(k)) ? hi[KW-1:0] : k;
  assign mag_sum = {1'b0, mag_r} + (DW+1)'(1);
  assign half    = mag_sum[DW:1];

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      trap_pkg::PL_SQ_MUL: begin
        mul_a = DW'(cand);
        mul_b = {1'b0, cand} + (KW+1)'(1);
      end
      trap_pkg::PL_MIN: begin
        mul_a = DW'(accel);
        mul_b = {1'b0, n1};
      end
      trap_pkg::PL_V: begin
        mul_a = prod[DW-1:0];
        mul_b = {1'b0, ramp_ticks} + (KW+1)'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trap_pkg::PL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    stat.busy  = (state != trap_pkg::PL_IDLE);
    stat.done  = 1'b0;
    unique case (state)
      trap_pkg::PL_IDLE: begin
        if (start) begin
          div_start  = 1'b1;
          div_a      = DW'(speed_limit);
          div_b      = DW'(accel);
          state_next = trap_pkg::PL_HI;
        end
      end
      trap_pkg::PL_HI: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = mag_r;
          div_b      = DW'(accel);
          state_next = trap_pkg::PL_Q;
        end
      end
      trap_pkg::PL_Q: begin
        if (div_done) begin
          state_next = trap_pkg::PL_SQ_MUL;
        end
      end
      trap_pkg::PL_SQ_MUL: state_next = trap_pkg::PL_SQ_CHK;
      trap_pkg::PL_SQ_CHK: begin
        state_next = (bitn == '0) ? trap_pkg::PL_MIN : trap_pkg::PL_SQ_MUL;
      end
      trap_pkg::PL_MIN: begin
        if (n1 == '0) begin
          stat.done  = 1'b1;
          state_next = trap_pkg::PL_IDLE;
        end else begin
          state_next = trap_pkg::PL_V;
        end
      end
      trap_pkg::PL_V: state_next = trap_pkg::PL_REM;
      trap_pkg::PL_REM: begin
        div_start  = 1'b1;
        div_a      = mag_r - prod[DW-1:0];
        div_b      = peak_speed;
        state_next = trap_pkg::PL_CRUISE;
      end
      trap_pkg::PL_CRUISE: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = peak_speed - div_r;
          div_b      = DW'(ramp_ticks);
          state_next = trap_pkg::PL_OFFS;
        end
      end
      trap_pkg::PL_OFFS: begin
        if (div_done) begin
          stat.done  = 1'b1;
          state_next = trap_pkg::PL_IDLE;
        end
      end
      default: state_next = trap_pkg::PL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      trap_pkg::PL_IDLE: begin
        if (start) begin
          mag_r <= mag;
        end
      end
      trap_pkg::PL_HI: begin
        if (div_done) begin
          hi <= div_q;
        end
      end
      trap_pkg::PL_Q: begin
        if (div_done) begin
          q    <= div_q;
          k    <= '0;
          bitn <= BW'(KW - 1);
        end
      end
      trap_pkg::PL_SQ_CHK: begin
        // keep the bit if cand*(cand+1) still fits under distance/accel
        if (prod <= PW'(q)) begin
          k <= cand;
        end
        bitn <= bitn - BW'(1);
      end
      trap_pkg::PL_MIN: begin
        if (n1 == '0) begin
          // no full ramp step fits: split over two ticks
          ramp_ticks   <= KW'(1);
          extra_dec    <= KW'(mag_r[0]);
          ramp_inc     <= half;
          ramp_offset  <= '0;
          cruise_ticks <= '0;
          peak_speed   <= '0;
          ramp_top     <= half;
        end else begin
          ramp_ticks <= n1;
          ramp_inc   <= DW'(accel);
        end
      end
      trap_pkg::PL_V: begin
        peak_speed <= prod[DW-1:0];
        ramp_top   <= prod[DW-1:0];
      end
      trap_pkg::PL_CRUISE: begin
        if (div_done) begin
          cruise_ticks <= div_q + DW'(1);
        end
      end
      trap_pkg::PL_OFFS: begin
        if (div_done) begin
          ramp_offset <= div_q[SPEED_BITS-1:0];
          extra_dec   <= div_r[KW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/trap_chk.sv =====
module trap_chk (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_func,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_start_refused
);

  // a result stays offered until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  // every accepted word shows a result on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no result after an accepted word");

  // a stalled output register blocks the input side
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input taken while output stalled");

  // a tick never reports a refused start
  a_tick_not_refused: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_func |=> !rsp_start_refused)
    else $error("tick reported as refused start");

endmodule

bind trapezoid_step_rate_profile_top trap_chk u_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_func          (req.func),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_start_refused (rsp.start_refused)
);
